// File: hw/rtl/tts_pkg.sv
// tts_pkg: shared types, constants and helpers of the text terminal screen engine
// used by tts_cursor_calc and text_terminal_screen_engine_top
package tts_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_LINES   = 32;
  localparam int TAB_WIDTH   = 8;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_LINES);
  localparam int CCOL_W = COL_W + 1;
  localparam int RCNT_W = ROW_W + 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELLS  = MAX_COLUMNS * MAX_LINES;

  localparam logic [CCOL_W-1:0] COLS_RESET = CCOL_W'(40);
  localparam logic [RCNT_W-1:0] ROWS_RESET = RCNT_W'(28);

  // configuration register indexes
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // control characters
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // csi final bytes
  localparam logic [7:0] CSI_A = 8'h41;
  localparam logic [7:0] CSI_B = 8'h42;
  localparam logic [7:0] CSI_C = 8'h43;
  localparam logic [7:0] CSI_D = 8'h44;
  localparam logic [7:0] CSI_H = 8'h48;
  localparam logic [7:0] CSI_J = 8'h4A;
  localparam logic [7:0] CSI_K = 8'h4B;

  typedef enum logic [1:0] {
    ACT_PRINT = 2'd0,
    ACT_CTRL  = 2'd1,
    ACT_CSI   = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ERASE = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  typedef struct packed {
    logic [CCOL_W-1:0] col;
    logic [ROW_W-1:0]  line;
  } cursor_t;

  typedef struct packed {
    logic             go;
    logic [ROW_W-1:0] r0;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c1;
  } erase_t;

  function automatic logic [CCOL_W-1:0] cols_clamp(input logic [CCOL_W-1:0] v);
    logic [CCOL_W-1:0] r;
    r = v;
    if (v == '0) r = CCOL_W'(1);
    else if (v > CCOL_W'(MAX_COLUMNS)) r = CCOL_W'(MAX_COLUMNS);
    return r;
  endfunction

  function automatic logic [RCNT_W-1:0] rows_clamp(input logic [RCNT_W-1:0] v);
    logic [RCNT_W-1:0] r;
    r = v;
    if (v == '0) r = RCNT_W'(1);
    else if (v > RCNT_W'(MAX_LINES)) r = RCNT_W'(MAX_LINES);
    return r;
  endfunction

endpackage

// File: hw/rtl/text_terminal_screen_engine_top.sv
// text_terminal_screen_engine_top: cell store, cursor, erase walker and result register
// depends on tts_pkg and tts_cursor_calc
//
// in_* carries one decoded terminal action per item, out_* returns one result item
// per input item: cursor column and row after the action and the glyph of a read.
// cfg_* writes the column count (index 0) and row count (index 1); the cursor is
// pulled back inside the new screen on the write.
// Path from the accept edge to out_tvalid:
//   print, control character, cursor move, positioning: result register directly
//   read cell: ST_READ, then result register (registered read of the cell memory)
//   erase: ST_ERASE while the walker clears each cell, then result register
// The erase walker writes one cell a cycle through the memory write port, which
// sets the erase time. One item is in work at a time; in_tready is high when the
// sequencer is idle and the result register is empty or being taken.
// After reset a clearing pass zeroes all 2048 cells, one a cycle, with in_tready
// low until it ends; configuration writes are taken meanwhile.
// When the receiver stalls the result is held in out_tdata and no new item is taken.
module text_terminal_screen_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // code, param_first, param_second, param_count,
                                  // read_column, read_line
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cursor_column_out, cursor_line_out, cell_glyph
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);
  import tts_pkg::*;

  state_t            st_r, st_nxt;
  logic [CCOL_W-1:0] cols_r, cols_nxt;
  logic [RCNT_W-1:0] rows_r, rows_nxt;
  logic [CCOL_W-1:0] cols_eff, cols_new;
  logic [RCNT_W-1:0] rows_eff, rows_new;
  cursor_t           cursor_r, cursor_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ROW_W-1:0]  wk_row_r, wk_end_row_r;
  logic [COL_W-1:0]  wk_col_r, wk_end_col_r;
  logic              wk_done;
  logic              out_valid_r, out_valid_nxt;
  logic [CCOL_W-1:0] out_col_r;
  logic [ROW_W-1:0]  out_line_r;
  logic [7:0]        out_glyph_r;
  logic              out_load;
  cursor_t           out_cur;
  logic [7:0]        out_glyph;
  logic              rd_ok_r;
  logic [7:0]        rd_q_r;

  logic [7:0]        cells_mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  action_t           act;
  logic              accept;
  logic              rd_ok;
  cursor_t           calc_nxt;
  cursor_t           print_at;
  erase_t            erase;

  assign act      = action_t'(in_tuser);
  assign cols_eff = cols_clamp(cols_r);
  assign rows_eff = rows_clamp(rows_r);
  assign in_tready = (st_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign rd_ok     = ({1'b0, in_tdata[50:45]} < cols_eff) && ({1'b0, in_tdata[55:51]} < rows_eff);
  assign wk_done   = (wk_row_r == wk_end_row_r) && (wk_col_r == wk_end_col_r);

  tts_cursor_calc u_calc (
    .cur          (cursor_r),
    .cols         (cols_eff),
    .rows         (rows_eff),
    .action       (act),
    .code         (in_tdata[7:0]),
    .param_first  (in_tdata[23:8]),
    .param_second (in_tdata[39:24]),
    .param_count  (in_tdata[44:40]),
    .nxt          (calc_nxt),
    .print_at     (print_at),
    .erase        (erase)
  );

  // configuration and cursor
  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (cfg_wr_en && cfg_index == CFG_COLS) cols_nxt = cfg_wdata;
    if (cfg_wr_en && cfg_index == CFG_ROWS) rows_nxt = cfg_wdata[RCNT_W-1:0];
    cols_new = cols_clamp(cols_nxt);
    rows_new = rows_clamp(rows_nxt);

    cursor_nxt = cursor_r;
    if (cfg_wr_en) begin
      if (cursor_r.col > cols_new) cursor_nxt.col = cols_new;
      if ({1'b0, cursor_r.line} >= rows_new) begin
        cursor_nxt.line = ROW_W'(rows_new - RCNT_W'(1));
      end
    end else if (accept && act != ACT_READ) begin
      cursor_nxt = calc_nxt;
    end
  end

  // sequencer and result register
  always_comb begin
    st_nxt    = st_r;
    out_load  = 1'b0;
    out_cur   = cursor_r;
    out_glyph = 8'd0;
    mem_we    = 1'b0;
    mem_waddr = {wk_row_r, wk_col_r};
    mem_wdata = 8'd0;
    case (st_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == '1) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = {print_at.line, print_at.col[COL_W-1:0]};
              mem_wdata = in_tdata[7:0];
              out_load  = 1'b1;
              out_cur   = calc_nxt;
            end
            ACT_READ: st_nxt = ST_READ;
            default: begin
              if (erase.go) begin
                st_nxt = ST_ERASE;
              end else begin
                out_load = 1'b1;
                out_cur  = calc_nxt;
              end
            end
          endcase
        end
      end
      ST_ERASE: begin
        mem_we = 1'b1;
        if (wk_done) begin
          st_nxt   = ST_IDLE;
          out_load = 1'b1;
        end
      end
      ST_READ: begin
        st_nxt    = ST_IDLE;
        out_load  = 1'b1;
        out_glyph = rd_ok_r ? rd_q_r : 8'd0;
      end
      default: st_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      cols_r      <= COLS_RESET;
      rows_r      <= ROWS_RESET;
      cursor_r    <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_r == ST_CLEAR) clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // erase walker, result payload
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && accept && erase.go) begin
      wk_row_r     <= erase.r0;
      wk_col_r     <= erase.c0;
      wk_end_row_r <= erase.r1;
      wk_end_col_r <= erase.c1;
    end else if (st_r == ST_ERASE) begin
      if (wk_col_r == COL_W'(cols_eff - CCOL_W'(1))) begin
        wk_col_r <= '0;
        wk_row_r <= wk_row_r + ROW_W'(1);
      end else begin
        wk_col_r <= wk_col_r + COL_W'(1);
      end
    end
    if (out_load) begin
      out_col_r   <= out_cur.col;
      out_line_r  <= out_cur.line;
      out_glyph_r <= out_glyph;
    end
    if (accept && act == ACT_READ) rd_ok_r <= rd_ok;
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (mem_we) cells_mem[mem_waddr] <= mem_wdata;
    if (accept && act == ACT_READ) rd_q_r <= cells_mem[{in_tdata[55:51], in_tdata[50:45]}];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_glyph_r, out_line_r, out_col_r};

  a_cursor_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r.col <= cols_eff) && ({1'b0, cursor_r.line} < rows_eff))
    else $error("cursor outside screen");

  a_walker_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ERASE) |-> ({1'b0, wk_row_r} < rows_eff))
    else $error("erase walker beyond last row");

  a_erase_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ERASE && wk_done) |=> (st_r == ST_IDLE && out_valid_r))
    else $error("erase end without result");

  a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_READ) |-> !out_valid_r)
    else $error("read result would overwrite pending result");

endmodule

// File: hw/rtl/tts_cursor_calc.sv
// tts_cursor_calc: next cursor, print position and erase range for one item
// depends on tts_pkg
module tts_cursor_calc (
  input  tts_pkg::cursor_t                cur,
  input  logic [tts_pkg::CCOL_W-1:0]      cols,
  input  logic [tts_pkg::RCNT_W-1:0]      rows,
  input  tts_pkg::action_t                action,
  input  logic [7:0]                      code,
  input  logic [15:0]                     param_first,
  input  logic [15:0]                     param_second,
  input  logic [4:0]                      param_count,
  output tts_pkg::cursor_t                nxt,
  output tts_pkg::cursor_t                print_at,
  output tts_pkg::erase_t                 erase
);
  import tts_pkg::*;

  logic [ROW_W-1:0]  line_dn;
  logic [15:0]       n;
  logic [16:0]       sum_l;
  logic [16:0]       sum_c;
  logic [CCOL_W:0]   tab_sum;
  logic [15:0]       h_col;
  logic [15:0]       h_row;
  logic [ROW_W-1:0]  rmax;
  logic [COL_W-1:0]  cmax;
  logic [COL_W-1:0]  cur_e;
  logic [CCOL_W-1:0] cols_m1;
  logic [RCNT_W-1:0] rows_m1;

  always_comb begin
    cols_m1 = cols - CCOL_W'(1);
    rows_m1 = rows - RCNT_W'(1);
    rmax    = rows_m1[ROW_W-1:0];
    cmax    = cols_m1[COL_W-1:0];
    cur_e   = (cur.col >= cols) ? cmax : cur.col[COL_W-1:0];
    line_dn = (({1'b0, cur.line} + RCNT_W'(1)) < rows) ? cur.line + ROW_W'(1) : cur.line;
    n       = (param_first == '0) ? 16'd1 : param_first;
    sum_l   = {12'b0, cur.line} + {1'b0, n};
    sum_c   = {10'b0, cur.col} + {1'b0, n};
    tab_sum = {1'b0, cur.col} + (CCOL_W + 1)'(TAB_WIDTH);
    h_col   = (param_second == '0) ? 16'd0 : param_second - 16'd1;
    h_row   = (param_first == '0) ? 16'd0 : param_first - 16'd1;

    nxt      = cur;
    print_at = cur;
    erase    = '0;

    case (action)
      ACT_PRINT: begin
        if (cur.col >= cols) begin
          print_at.col  = '0;
          print_at.line = line_dn;
        end
        nxt.col  = print_at.col + CCOL_W'(1);
        nxt.line = print_at.line;
      end
      ACT_CTRL: begin
        case (code)
          CH_BS:  if (cur.col != '0) nxt.col = cur.col - CCOL_W'(1);
          CH_LF: begin
            nxt.col  = '0;
            nxt.line = line_dn;
          end
          CH_CR:  nxt.col = '0;
          CH_TAB: begin
            if (tab_sum >= {1'b0, cols}) begin
              if (cur.col < cols) nxt.col = cols_m1;
            end else begin
              nxt.col = tab_sum[CCOL_W-1:0];
            end
          end
          CH_VT:  nxt.line = line_dn;
          default: ;
        endcase
      end
      ACT_CSI: begin
        if (code == CSI_H) begin
          if (param_count == 5'd0) begin
            nxt = '0;
          end else if (param_count == 5'd2) begin
            if (h_col < {9'b0, cols} && h_row < {10'b0, rows}) begin
              nxt.col  = h_col[CCOL_W-1:0];
              nxt.line = h_row[ROW_W-1:0];
            end
          end
        end else if (param_count != 5'd0) begin
          case (code)
            CSI_A: nxt.line = (n > {11'b0, cur.line}) ? '0 : cur.line - n[ROW_W-1:0];
            CSI_B: nxt.line = (sum_l >= {11'b0, rows}) ? rmax : sum_l[ROW_W-1:0];
            CSI_C: nxt.col  = (sum_c >= {10'b0, cols}) ? cols_m1 : sum_c[CCOL_W-1:0];
            CSI_D: nxt.col  = (n > {9'b0, cur.col}) ? '0 : cur.col - n[CCOL_W-1:0];
            CSI_J, CSI_K: begin
              if (param_first == 16'd0) begin
                erase.go = 1'b1;
                erase.r0 = cur.line;
                erase.c0 = cur_e;
                erase.r1 = (code == CSI_J) ? rmax : cur.line;
                erase.c1 = cmax;
              end else if (param_first == 16'd1) begin
                erase.go = 1'b1;
                erase.r0 = (code == CSI_J) ? '0 : cur.line;
                erase.c0 = '0;
                erase.r1 = cur.line;
                erase.c1 = cur_e;
              end else if (param_first == 16'd2) begin
                erase.go = 1'b1;
                erase.r0 = (code == CSI_J) ? '0 : cur.line;
                erase.c0 = '0;
                erase.r1 = (code == CSI_J) ? rmax : cur.line;
                erase.c1 = cmax;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule
